// ----- rtl/bqf_pkg.sv -----
`default_nettype none

package bqf_pkg;

  // Fixed field widths
  localparam int COEF_WIDTH      = 24;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int CFG_COUNT       = 5;
  localparam int CFG_INDEX_WIDTH = 3;

  // Operand chunk of the shared multiplier (coef magnitude x chunk)
  localparam int MUL_CHUNK = 32;

  // Parameter defaults
  localparam int DEF_COEF_FRAC_BITS = 20;
  localparam int DEF_STATE_WIDTH    = 48;

  // Reset value of coef_ff0 (unity gain at 20 fractional bits)
  localparam logic [COEF_WIDTH-1:0] COEF_FF0_RESET = 24'd1048576;

  // Output limits
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'h8000;

  // Product being worked on; the value also indexes the coefficient registers
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    OP_FF0 = 3'd0,
    OP_FF1 = 3'd1,
    OP_FF2 = 3'd2,
    OP_FB1 = 3'd3,
    OP_FB2 = 3'd4
  } op_t;

  // Control of the scale / saturate / combine unit
  typedef struct packed {
    logic use_acc;   // feedback product: take the accumulator and scale it down
    logic subtract;  // subtract the product from the base instead of adding it
  } comb_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/bqf_mul.sv -----
`default_nettype none

module bqf_mul (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic [bqf_pkg::COEF_WIDTH-1:0]                a,
  input  wire logic [bqf_pkg::MUL_CHUNK-1:0]                 b,
  output logic      [bqf_pkg::COEF_WIDTH+bqf_pkg::MUL_CHUNK-1:0] prod
);
  import bqf_pkg::*;

  localparam int PW = COEF_WIDTH + MUL_CHUNK;

  // Unsigned magnitude multiply, result registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(a) * PW'(b);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bqf_comb.sv -----
`default_nettype none

module bqf_comb #(
  parameter int STATE_WIDTH    = bqf_pkg::DEF_STATE_WIDTH,
  parameter int COEF_FRAC_BITS = bqf_pkg::DEF_COEF_FRAC_BITS,
  parameter int ACC_WIDTH      = bqf_pkg::COEF_WIDTH + 2 * bqf_pkg::MUL_CHUNK
) (
  input  wire bqf_pkg::comb_ctrl_t                                 ctrl,
  input  wire logic [bqf_pkg::COEF_WIDTH+bqf_pkg::MUL_CHUNK-1:0]    prod,
  input  wire logic [ACC_WIDTH-1:0]                                acc,
  input  wire logic                                                neg,
  input  wire logic [STATE_WIDTH-1:0]                              base,
  output logic      [STATE_WIDTH-1:0]                              result
);
  import bqf_pkg::*;

  localparam int SW = STATE_WIDTH;

  localparam logic [SW-1:0] CAP    = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] ST_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] ST_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [ACC_WIDTH-1:0] q;
  logic                 over;
  logic [SW-1:0]        mag;
  logic                 eff_neg;
  logic [SW:0]          sum;

  // Scale (feedback products truncate toward zero on the magnitude)
  assign q    = ctrl.use_acc ? (acc >> COEF_FRAC_BITS) : ACC_WIDTH'(prod);
  assign over = |q[ACC_WIDTH-1:SW-1];

  // Saturate the signed product to the state range
  always_comb begin
    if (over) begin
      mag = neg ? CAP : ST_MAX;
    end else begin
      mag = q[SW-1:0];
    end
  end

  // base +/- product, one adder with carry-in
  assign eff_neg = neg ^ ctrl.subtract;
  assign sum = {base[SW-1], base}
             + ({1'b0, mag} ^ {(SW+1){eff_neg}})
             + (SW+1)'(eff_neg);

  // Clamp to the state range
  always_comb begin
    if (sum[SW] != sum[SW-1]) begin
      result = sum[SW] ? ST_MIN : ST_MAX;
    end else begin
      result = sum[SW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bqf_out_stage.sv -----
`default_nettype none

module bqf_out_stage #(
  parameter int STATE_WIDTH    = bqf_pkg::DEF_STATE_WIDTH,
  parameter int COEF_FRAC_BITS = bqf_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               load,
  input  wire logic [STATE_WIDTH-1:0]             y_mag,
  input  wire logic                               y_neg,
  output logic                                    free,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [bqf_pkg::SAMPLE_WIDTH-1:0]   filtered,
  output logic                                    clipped
);
  import bqf_pkg::*;

  localparam int SW = STATE_WIDTH;
  localparam logic [SW-1:0] POS_LIMIT = SW'(2 ** (SAMPLE_WIDTH - 1) - 1);
  localparam logic [SW-1:0] NEG_LIMIT = SW'(2 ** (SAMPLE_WIDTH - 1));

  logic [SW-1:0]           qm;
  logic                    clip_next;
  logic [SAMPLE_WIDTH-1:0] filtered_next;

  assign free = !out_valid || out_ready;

  // Truncate toward zero on the magnitude, then clamp to 16 bits
  assign qm = y_mag >> COEF_FRAC_BITS;

  always_comb begin
    if (y_neg) begin
      clip_next     = qm > NEG_LIMIT;
      filtered_next = clip_next ? SAMPLE_MIN : -qm[SAMPLE_WIDTH-1:0];
    end else begin
      clip_next     = qm > POS_LIMIT;
      filtered_next = clip_next ? SAMPLE_MAX : qm[SAMPLE_WIDTH-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered <= filtered_next;
      clipped  <= clip_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/biquad_iir_filter_core.sv -----
// Second-order IIR section, transposed direct form II, with two state banks.
//
// Channels (valid/ready, item moves when both are high):
//   input  : bank, sample        -- bank picks one of two delay-state pairs
//   output : filtered, clipped   -- one item per input item, in order
//   config : cfg_index, cfg_data -- coefficients ff0, ff1, ff2, fb1, fb2
//            (index 0..4); other indexes are dropped. cfg_ready is always
//            high; write only while no item is in flight.
//
// Sequence: one 24x32 multiplier does all five products, one at a time. Each
// product runs through the multiply state and then the combine state; feedback
// products also pass through the accumulate state once for each chunk, since
// the output is multiplied in 32-bit chunks. The finished item then goes to the
// output register, and only after that does in_ready return, so the core takes
// no new input item while one is in flight.
//
// Reset clears both delay banks and loads the default coefficients (unity
// pass-through). If the output is stalled, the finished item waits in the core
// until the output register is free; only then is the next input item taken.
`default_nettype none

module biquad_iir_filter_core #(
  parameter int COEF_FRAC_BITS = bqf_pkg::DEF_COEF_FRAC_BITS,
  parameter int STATE_WIDTH    = bqf_pkg::DEF_STATE_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // input items
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   bank,
  input  wire logic [bqf_pkg::SAMPLE_WIDTH-1:0]       sample,
  // result items
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic      [bqf_pkg::SAMPLE_WIDTH-1:0]       filtered,
  output logic                                        clipped,
  // coefficient writes
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [bqf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [bqf_pkg::COEF_WIDTH-1:0]         cfg_data
);
  import bqf_pkg::*;

  localparam int SW   = STATE_WIDTH;
  localparam int NCH  = (STATE_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int YW   = NCH * MUL_CHUNK;
  localparam int PW   = COEF_WIDTH + MUL_CHUNK;
  localparam int AW   = COEF_WIDTH + YW;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NCH - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_COMB = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                  state;
  op_t                     op;
  logic [CH_W-1:0]         ch;
  logic                    bank_q;
  logic [SAMPLE_WIDTH-1:0] x_mag;
  logic                    x_neg;
  logic [SW-1:0]           y;
  logic [SW-1:0]           y_mag;
  logic                    y_neg;
  logic [SW-1:0]           t_val;
  logic [SW-1:0]           u_val;
  logic [SW-1:0]           d1 [2];
  logic [SW-1:0]           d2 [2];
  logic [AW-1:0]           acc;
  logic [AW-1:0]           acc_next;
  logic [COEF_WIDTH-1:0]   coef_mag [CFG_COUNT];
  logic                    coef_neg [CFG_COUNT];

  logic                    is_fb;
  logic                    mul_en;
  logic [CH_W-1:0]         mul_ch;
  logic [YW-1:0]           y_mag_ext;
  logic [MUL_CHUNK-1:0]    mul_b;
  logic [PW-1:0]           prod;
  comb_ctrl_t              cctrl;
  logic                    prod_neg;
  logic [SW-1:0]           base;
  logic [SW-1:0]           result;
  logic                    out_free;
  logic                    out_load;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Coefficients kept as sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        coef_mag[i] <= (i == int'(OP_FF0)) ? COEF_FF0_RESET : '0;
        coef_neg[i] <= 1'b0;
      end
    end else if (cfg_valid && (cfg_index < CFG_INDEX_WIDTH'(CFG_COUNT))) begin
      coef_mag[cfg_index] <= cfg_data[COEF_WIDTH-1] ? -cfg_data : cfg_data;
      coef_neg[cfg_index] <= cfg_data[COEF_WIDTH-1];
    end
  end

  // Multiplier operands
  assign is_fb     = (op == OP_FB1) || (op == OP_FB2);
  assign mul_ch    = (state == ST_ACC) ? ch + 1'b1 : ch;
  assign mul_en    = (state == ST_MUL) || ((state == ST_ACC) && (ch != CH_LAST));
  assign y_mag_ext = YW'(y_mag);
  assign mul_b     = is_fb ? y_mag_ext[mul_ch * MUL_CHUNK +: MUL_CHUNK]
                           : MUL_CHUNK'(x_mag);

  bqf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (coef_mag[op]),
    .b    (mul_b),
    .prod (prod)
  );

  // Chunk accumulation for feedback products
  assign acc_next = ((ch == '0) ? '0 : acc) + (AW'(prod) << (ch * MUL_CHUNK));

  always_ff @(posedge clk) begin
    if (state == ST_ACC) begin
      acc <= acc_next;
    end
  end

  // Base operand and add/subtract per product
  always_comb begin
    unique case (op)
      OP_FF0: base = d1[bank_q];
      OP_FF1: base = d2[bank_q];
      OP_FF2: base = '0;
      OP_FB1: base = t_val;
      OP_FB2: base = u_val;
      default: base = '0;
    endcase
  end

  assign cctrl.use_acc  = is_fb;
  assign cctrl.subtract = is_fb;
  assign prod_neg       = coef_neg[op] ^ (is_fb ? y_neg : x_neg);

  bqf_comb #(
    .STATE_WIDTH    (STATE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_WIDTH      (AW)
  ) u_comb (
    .ctrl   (cctrl),
    .prod   (prod),
    .acc    (acc),
    .neg    (prod_neg),
    .base   (base),
    .result (result)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_FF0;
      ch    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL;
            op    <= OP_FF0;
            ch    <= '0;
          end
        end
        ST_MUL: begin
          ch    <= '0;
          state <= is_fb ? ST_ACC : ST_COMB;
        end
        ST_ACC: begin
          if (ch == CH_LAST) begin
            state <= ST_COMB;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        ST_COMB: begin
          if (op == OP_FB2) begin
            state <= ST_OUT;
          end else begin
            op    <= op_t'(op + 1'b1);
            ch    <= '0;
            state <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Input item capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bank_q <= bank;
      x_neg  <= sample[SAMPLE_WIDTH-1];
      x_mag  <= sample[SAMPLE_WIDTH-1] ? -sample : sample;
    end
  end

  // Intermediate results
  always_ff @(posedge clk) begin
    if (state == ST_COMB) begin
      unique case (op)
        OP_FF0: y     <= result;
        OP_FF1: t_val <= result;
        OP_FF2: u_val <= result;
        default: ;
      endcase
    end
  end

  // Output magnitude and sign, registered from y
  always_ff @(posedge clk) begin
    y_neg <= y[SW-1];
    y_mag <= y[SW-1] ? -y : y;
  end

  // Delay state, both banks
  always_ff @(posedge clk) begin
    if (rst) begin
      d1[0] <= '0;
      d1[1] <= '0;
      d2[0] <= '0;
      d2[1] <= '0;
    end else if (state == ST_COMB) begin
      if (op == OP_FB1) begin
        d1[bank_q] <= result;
      end
      if (op == OP_FB2) begin
        d2[bank_q] <= result;
      end
    end
  end

  assign out_load = (state == ST_OUT) && out_free;

  bqf_out_stage #(
    .STATE_WIDTH    (STATE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .y_mag     (y_mag),
    .y_neg     (y_neg),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .clipped   (clipped)
  );

  // Checks
  a_acc_fb_only: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> (op == OP_FB1 || op == OP_FB2))
    else $error("accumulate state entered for a feed-forward product");

  a_chunk_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> ch <= CH_LAST)
    else $error("chunk counter out of range");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> $stable(x_mag) && $stable(bank_q))
    else $error("item operands changed while in flight");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_free |=> out_valid && state == ST_IDLE)
    else $error("finished item not presented");

  a_clip_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> filtered == SAMPLE_MAX || filtered == SAMPLE_MIN)
    else $error("clipped item not at a limit");

endmodule

`default_nettype wire

// ----- tb/sv/bqf_result_checker.sv -----
module bqf_result_checker #(
  parameter int COEF_FRAC_BITS = bqf_pkg::DEF_COEF_FRAC_BITS,
  parameter int STATE_WIDTH    = bqf_pkg::DEF_STATE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                bank,
  input  logic [bqf_pkg::SAMPLE_WIDTH-1:0]    sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [bqf_pkg::SAMPLE_WIDTH-1:0]    filtered,
  input  logic                                clipped,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [bqf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bqf_pkg::COEF_WIDTH-1:0]      cfg_data,
  output int                                  errors,
  output int                                  outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import bqf_pkg::*;

  // wide enough for a coefficient times a full state value
  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] filtered;
    logic                    clipped;
  } result_t;

  localparam acc_t STATE_MAX = (acc_t'(1) <<< (STATE_WIDTH - 1)) - acc_t'(1);
  localparam acc_t STATE_MIN = -STATE_MAX - acc_t'(1);

  logic signed [COEF_WIDTH-1:0] coefs [CFG_COUNT];
  acc_t    delay1 [2];
  acc_t    delay2 [2];
  result_t expected_outputs [$];
  result_t want;
  result_t got;
  int      fail_count = 0;

  function automatic acc_t clamp_state(acc_t v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  // c*y scaled down with truncation toward zero, then saturated
  function automatic acc_t scale_feedback(acc_t c, acc_t y);
    acc_t p;
    acc_t m;
    p = c * y;
    m = (p < 0) ? -p : p;
    m = m >> COEF_FRAC_BITS;
    return clamp_state((p < 0) ? -m : m);
  endfunction

  // one sample through the selected bank; updates that bank's delay pair
  function automatic result_t filter_step(logic sel, logic signed [SAMPLE_WIDTH-1:0] x_in);
    acc_t    x;
    acc_t    y;
    acc_t    t;
    acc_t    mag;
    result_t r;
    x = acc_t'(x_in);
    y = clamp_state(clamp_state(x * acc_t'(coefs[OP_FF0])) + delay1[sel]);
    t = clamp_state(clamp_state(x * acc_t'(coefs[OP_FF1])) + delay2[sel]);
    delay1[sel] = clamp_state(t - scale_feedback(acc_t'(coefs[OP_FB1]), y));
    delay2[sel] = clamp_state(clamp_state(x * acc_t'(coefs[OP_FF2]))
                              - scale_feedback(acc_t'(coefs[OP_FB2]), y));
    mag = ((y < 0) ? -y : y) >> COEF_FRAC_BITS;
    r.clipped = 1'b0;
    if (y < 0) begin
      // exactly full scale negative is representable, not a clip
      if (mag > 32768) begin
        r.filtered = SAMPLE_MIN;
        r.clipped  = 1'b1;
      end else begin
        r.filtered = SAMPLE_WIDTH'(-mag);
      end
    end else begin
      if (mag > 32767) begin
        r.filtered = SAMPLE_MAX;
        r.clipped  = 1'b1;
      end else begin
        r.filtered = SAMPLE_WIDTH'(mag);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      coefs[OP_FF0] = COEF_FF0_RESET;
      coefs[OP_FF1] = '0;
      coefs[OP_FF2] = '0;
      coefs[OP_FB1] = '0;
      coefs[OP_FB2] = '0;
      delay1[0] = '0;
      delay1[1] = '0;
      delay2[0] = '0;
      delay2[1] = '0;
      expected_outputs.delete();
    end else begin
      // coefficient writes; unused indexes are dropped
      if (cfg_valid && cfg_ready && cfg_index < CFG_COUNT) begin
        coefs[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        expected_outputs.push_back(filter_step(bank, sample));
      end
      // compare each result item against the oldest prediction
      if (out_valid && out_ready) begin
        got.filtered = filtered;
        got.clipped  = clipped;
        if (expected_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected result item filtered=%0d clipped=%0b",
                     $realtime, $signed(got.filtered), got.clipped);
          end
        end else begin
          want = expected_outputs.pop_front();
          if (got.filtered !== want.filtered || got.clipped !== want.clipped) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch: filtered exp %0d got %0d, clipped exp %0b got %0b",
                       $realtime, $signed(want.filtered), $signed(got.filtered),
                       want.clipped, got.clipped);
            end
          end
        end
      end
    end
    errors      <= fail_count;
    outstanding <= expected_outputs.size();
  end

endmodule

// ----- tb/sv/tb_biquad_iir_filter_core.sv -----
module tb_biquad_iir_filter_core;

  timeunit 1ns;
  timeprecision 1ps;

  import bqf_pkg::*;

  typedef logic [COEF_WIDTH-1:0] coef_set_t [CFG_COUNT];

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       bank      = 1'b0;
  logic [SAMPLE_WIDTH-1:0]    sample    = '0;
  logic                       out_ready = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [COEF_WIDTH-1:0]      cfg_data  = '0;
  logic                       in_ready;
  logic                       out_valid;
  logic [SAMPLE_WIDTH-1:0]    filtered;
  logic                       clipped;
  logic                       cfg_ready;
  int                         errors;
  int                         outstanding;

  biquad_iir_filter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .bank      (bank),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .clipped   (clipped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bqf_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .bank        (bank),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .filtered    (filtered),
    .clipped     (clipped),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("tb_biquad_iir_filter_core NOT OK");
    $finish;
  end

  // result side: alternates between free flow, frequent short stalls
  // and rare long stalls
  int rx_mode   = 0;
  int rx_cycles = 0;
  int rx_hold   = 0;

  always @(posedge clk) begin
    rx_cycles = rx_cycles + 1;
    if (rx_cycles % 400 == 0) rx_mode = $urandom_range(0, 2);
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(4, 40);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // present one sample item and hold it until taken
  task automatic push_sample(input logic b, input logic [SAMPLE_WIDTH-1:0] s);
    in_valid <= 1'b1;
    bank     <= b;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every result item is back and the core is free
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || !in_ready) @(posedge clk);
  endtask

  // write all five coefficients plus one write to an unused index
  task automatic load_coefs(input coef_set_t c);
    int i;
    drain();
    for (i = 0; i < CFG_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_INDEX_WIDTH'(i);
      cfg_data  <= c[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_index <= CFG_INDEX_WIDTH'($urandom_range(CFG_COUNT, 2 ** CFG_INDEX_WIDTH - 1));
    cfg_data  <= COEF_WIDTH'($urandom);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coef_set_t make_set(int ff0, int ff1, int ff2, int fb1, int fb2);
    coef_set_t c;
    c[OP_FF0] = COEF_WIDTH'(ff0);
    c[OP_FF1] = COEF_WIDTH'(ff1);
    c[OP_FF2] = COEF_WIDTH'(ff2);
    c[OP_FB1] = COEF_WIDTH'(fb1);
    c[OP_FB2] = COEF_WIDTH'(fb2);
    return c;
  endfunction

  // poles kept inside the stability triangle, moderate feed-forward taps
  function automatic coef_set_t stable_set();
    int a1;
    int a2;
    int lim;
    a2  = $urandom_range(0, 1900000) - 950000;
    lim = (1048576 + a2) * 95 / 100;
    a1  = $urandom_range(0, 2 * lim) - lim;
    return make_set($urandom_range(0, 2097152) - 1048576,
                    $urandom_range(0, 2097152) - 1048576,
                    $urandom_range(0, 2097152) - 1048576, a1, a2);
  endfunction

  // each tap at full scale either way, zero, or anything
  function automatic coef_set_t extreme_set();
    coef_set_t c;
    int        i;
    for (i = 0; i < CFG_COUNT; i++) begin
      case ($urandom_range(0, 3))
        0: c[i] = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
        1: c[i] = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
        2: c[i] = '0;
        default: c[i] = COEF_WIDTH'($urandom);
      endcase
    end
    return c;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return SAMPLE_WIDTH'($urandom_range(0, 512) - 256);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  initial begin
    coef_set_t set;
    int        phase;
    int        n;
    int        burst_left;
    int        drain_at;
    int        switch_odds;
    logic      gapless;
    logic      sel;

    sel = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unity pass-through after reset, full-scale and near-zero samples
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b1, SAMPLE_MIN);
    push_sample(1'b0, '0);
    push_sample(1'b1, SAMPLE_WIDTH'(-1));
    push_sample(1'b0, SAMPLE_WIDTH'(1));

    // gain of two: clip both ways, and an exact negative full scale that is not a clip
    load_coefs(make_set(2097152, 0, 0, 0, 0));
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b1, SAMPLE_MIN);
    push_sample(1'b0, SAMPLE_WIDTH'(-16384));
    push_sample(1'b1, SAMPLE_WIDTH'(16384));

    // gain of one half: negative results truncate toward zero
    load_coefs(make_set(524288, 0, 0, 0, 0));
    push_sample(1'b0, SAMPLE_WIDTH'(-1));
    push_sample(1'b1, SAMPLE_WIDTH'(-3));
    push_sample(1'b0, SAMPLE_WIDTH'(3));

    // all taps at full scale: runaway feedback saturates products and state
    load_coefs(make_set(8388607, -8388608, 8388607, -8388608, 8388607));
    for (n = 0; n < 8; n++) begin
      push_sample(n[1], n[0] ? SAMPLE_MIN : SAMPLE_MAX);
    end

    // random phases, each with its own coefficients and pacing
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set = make_set(70762, 141524, 70762, -1198521, 432852);
        1: set = make_set(669935, -1339870, 669935, -1198521, 432852);
        2, 6: set = extreme_set();
        default: set = stable_set();
      endcase
      load_coefs(set);
      gapless     = ($urandom_range(0, 3) == 0);
      switch_odds = $urandom_range(1, 16);
      drain_at    = $urandom_range(10, 90);
      burst_left  = $urandom_range(1, 32);
      for (n = 0; n < 103; n++) begin
        if ($urandom_range(1, switch_odds) == 1) sel = ~sel;
        push_sample(sel, rand_sample());
        if (n == drain_at) begin
          drain();
        end else if (!gapless) begin
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 32);
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_biquad_iir_filter_core OK");
    end else begin
      $display("tb_biquad_iir_filter_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bqf_pkg.sv
rtl/bqf_mul.sv
rtl/bqf_comb.sv
rtl/bqf_out_stage.sv
rtl/biquad_iir_filter_core.sv
tb/sv/bqf_result_checker.sv
tb/sv/tb_biquad_iir_filter_core.sv
